[hw/rtl/cthz_pkg.sv]
`timescale 1ns / 1ps
package cthz_pkg;

    localparam int NUM_LANES     = 4;
    localparam int NUM_TAPS      = 27;
    localparam int NUM_CHAN      = 3;
    localparam int NUM_KERN      = 6;
    localparam int KERN_BITS     = 60;
    localparam int COEFS_PER_WORD = 5;
    localparam int VALUE_BITS    = 32;
    localparam int COORD_BITS    = 10;
    localparam int SIZE_BITS     = 11;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 60;

    localparam logic [CFG_INDEX_BITS-1:0] REG_KERN_WORD0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERN_WORD5 = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT  = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_LENGTH = 3'd7;

    typedef logic [COORD_BITS-1:0] coord_t;

    // per-transaction bookkeeping that rides beside the lane pipelines
    typedef struct packed {
        logic [NUM_LANES-1:0]                 en;
        logic [NUM_LANES-1:0][COORD_BITS-1:0] row;
        logic [NUM_LANES-1:0][COORD_BITS-1:0] col;
    } lane_meta_t;

endpackage

[hw/rtl/cthz_pix_if.sv]
`timescale 1ns / 1ps
interface cthz_pix_if #(
    parameter int PIXEL_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] chan_a;
    logic signed [PIXEL_BITS-1:0] chan_b;
    logic signed [PIXEL_BITS-1:0] chan_c;

    modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
    modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

[hw/rtl/cthz_res_if.sv]
`timescale 1ns / 1ps
interface cthz_res_if ();
    import cthz_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] conv_value;
    logic [COORD_BITS-1:0]        out_row;
    logic [COORD_BITS-1:0]        out_col;
    logic                         frame_end;

    modport source (output valid, output conv_value, output out_row, output out_col,
                    output frame_end, input ready);
    modport sink   (input valid, input conv_value, input out_row, input out_col,
                    input frame_end, output ready);
endinterface

[hw/rtl/conv3x3_three_channel_zero_pad_top.sv]
`timescale 1ns / 1ps
// Throughput: one pixel per clock while each pixel yields at most one result and res_out
// is ready; pixels on the last column below row 0, or on the last row past column 0, yield
// two to four results, which leave one per clock through the single merge output while
// res_out is ready, holding off the input meanwhile.
// Reset clears positions, window, pipeline valids and registers to defaults;
// the line memory is not cleared (there is no clearing pass).
module conv3x3_three_channel_zero_pad_top #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int MAX_ROWS       = 1024,
    parameter int PIXEL_BITS     = 16,
    parameter int COEF_BITS      = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    cthz_pix_if.sink                              pix_in,
    cthz_res_if.source                            res_out,
    input  logic                                  cfg_we,
    input  logic [cthz_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [cthz_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import cthz_pkg::*;

    localparam int RB = $clog2(MAX_ROWS);
    localparam int CB = $clog2(MAX_ROW_LENGTH);
    localparam int PW = NUM_CHAN * PIXEL_BITS;

    // configuration
    logic [KERN_BITS-1:0] kern_reg [NUM_KERN];
    logic [SIZE_BITS-1:0] row_count_reg;
    logic [SIZE_BITS-1:0] row_length_reg;
    logic [63:0]          kern_wide [NUM_KERN];
    logic signed [COEF_BITS-1:0] coef_all [NUM_TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KERN; i++)
            begin
                kern_reg[i] <= '0;
            end
            row_count_reg  <= SIZE_BITS'(2);
            row_length_reg <= SIZE_BITS'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:  row_count_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_ROW_LENGTH: row_length_reg <= cfg_data[SIZE_BITS-1:0];
                default:        kern_reg[cfg_index] <= cfg_data;
            endcase
        end
    end

    genvar gk, gl, gt;
    generate
        for (gk = 0; gk < NUM_KERN; gk++)
        begin : g_wide
            assign kern_wide[gk] = 64'(kern_reg[gk]);
        end
        for (gk = 0; gk < NUM_TAPS; gk++)
        begin : g_coef
            localparam int WI = gk / COEFS_PER_WORD;
            localparam int SH = (gk % COEFS_PER_WORD) * COEF_BITS;
            if (SH + COEF_BITS <= 64)
            begin : g_fit
                assign coef_all[gk] = kern_wide[WI][SH +: COEF_BITS];
            end
            else
            begin : g_zero
                assign coef_all[gk] = '0;
            end
        end
    endgenerate

    // effective image size
    logic [RB:0] h_eff;
    logic [CB:0] w_eff;

    always_comb
    begin
        if (row_count_reg < SIZE_BITS'(2))
        begin
            h_eff = (RB+1)'(2);
        end
        else if (32'(row_count_reg) > 32'(MAX_ROWS))
        begin
            h_eff = (RB+1)'(MAX_ROWS);
        end
        else
        begin
            h_eff = (RB+1)'(row_count_reg);
        end
        if (row_length_reg < SIZE_BITS'(2))
        begin
            w_eff = (CB+1)'(2);
        end
        else if (32'(row_length_reg) > 32'(MAX_ROW_LENGTH))
        begin
            w_eff = (CB+1)'(MAX_ROW_LENGTH);
        end
        else
        begin
            w_eff = (CB+1)'(row_length_reg);
        end
    end

    // handshake and global advance
    logic adv;
    logic accept;
    logic can_take;
    logic d_valid_reg;

    assign adv          = !d_valid_reg || can_take;
    assign pix_in.ready = adv;
    assign accept       = pix_in.valid && adv;

    // raster position
    logic [RB-1:0] row_pos_reg;
    logic [CB-1:0] col_pos_reg;
    logic [RB-1:0] r_cur;
    logic [CB-1:0] c_cur;
    logic          restart;
    logic          last_row;
    logic          last_col;

    assign restart  = ({1'b0, row_pos_reg} >= h_eff) || ({1'b0, col_pos_reg} >= w_eff);
    assign r_cur    = restart ? '0 : row_pos_reg;
    assign c_cur    = restart ? '0 : col_pos_reg;
    assign last_row = ({1'b0, r_cur} == h_eff - (RB+1)'(1));
    assign last_col = ({1'b0, c_cur} == w_eff - (CB+1)'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= last_row ? '0 : r_cur + RB'(1);
            end
            else
            begin
                col_pos_reg <= c_cur + CB'(1);
                row_pos_reg <= r_cur;
            end
        end
    end

    // stage 1: pixel and line memory read
    logic                         s1_valid_reg;
    logic signed [PIXEL_BITS-1:0] s1_pix_reg [NUM_CHAN];
    logic [RB-1:0]                s1_r_reg;
    logic [CB-1:0]                s1_c_reg;
    logic                         s1_last_row_reg;
    logic                         s1_last_col_reg;
    logic [2*PW-1:0]              mem_rd;
    logic                         s1_adv;

    assign s1_adv = adv && s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg[0]   <= pix_in.chan_a;
            s1_pix_reg[1]   <= pix_in.chan_b;
            s1_pix_reg[2]   <= pix_in.chan_c;
            s1_r_reg        <= r_cur;
            s1_c_reg        <= c_cur;
            s1_last_row_reg <= last_row;
            s1_last_col_reg <= last_col;
        end
    end

    // low half holds the older line, high half the previous line
    cthz_line_mem #(
        .DEPTH (MAX_ROW_LENGTH),
        .WIDTH (2 * PW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .rd_data (mem_rd),
        .wr_en   (s1_adv),
        .wr_addr (s1_c_reg),
        .wr_data ({s1_pix_reg[2], s1_pix_reg[1], s1_pix_reg[0], mem_rd[2*PW-1:PW]})
    );

    // stage 2: window and lane setup; tap index = (wr*3 + wc)*3 + ch
    logic signed [PIXEL_BITS-1:0] win_reg [NUM_TAPS];
    logic                         s2_valid_reg;
    lane_meta_t                   s2_meta_reg;
    logic [NUM_LANES-1:0]         s2_top_ok_reg;
    logic [NUM_LANES-1:0]         s2_left_ok_reg;
    lane_meta_t                   s2_meta_next;
    logic [NUM_LANES-1:0]         top_ok_next;
    logic [NUM_LANES-1:0]         left_ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TAPS; t++)
            begin
                win_reg[t] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int wr = 0; wr < 3; wr++)
                begin
                    for (int ch = 0; ch < NUM_CHAN; ch++)
                    begin
                        win_reg[(wr*3+0)*3+ch] <= win_reg[(wr*3+1)*3+ch];
                        win_reg[(wr*3+1)*3+ch] <= win_reg[(wr*3+2)*3+ch];
                    end
                end
                // lines above the image enter as zero
                for (int ch = 0; ch < NUM_CHAN; ch++)
                begin
                    win_reg[(0*3+2)*3+ch] <= (s1_r_reg >= RB'(2))
                        ? mem_rd[ch*PIXEL_BITS +: PIXEL_BITS] : '0;
                    win_reg[(1*3+2)*3+ch] <= (s1_r_reg >= RB'(1))
                        ? mem_rd[PW + ch*PIXEL_BITS +: PIXEL_BITS] : '0;
                    win_reg[(2*3+2)*3+ch] <= s1_pix_reg[ch];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_meta_reg    <= s2_meta_next;
            s2_top_ok_reg  <= top_ok_next;
            s2_left_ok_reg <= left_ok_next;
        end
    end

    // lanes centered at window (1,1), (1,2), (2,1), (2,2)
    logic signed [COEF_BITS-1:0]  lane_coef [NUM_LANES][NUM_TAPS];
    logic signed [VALUE_BITS-1:0] lane_sum  [NUM_LANES];

    generate
        for (gl = 0; gl < NUM_LANES; gl++)
        begin : g_lane
            localparam int DR = (gl < 2) ? 1 : 0;
            localparam int DC = ((gl % 2) == 0) ? 1 : 0;
            localparam int CR = 2 - DR;
            localparam int CC = 2 - DC;

            assign s2_meta_next.en[gl] =
                (DR == 1 ? (s1_r_reg >= RB'(1)) : s1_last_row_reg) &&
                (DC == 1 ? (s1_c_reg >= CB'(1)) : s1_last_col_reg);
            assign s2_meta_next.row[gl] = COORD_BITS'(s1_r_reg - RB'(DR));
            assign s2_meta_next.col[gl] = COORD_BITS'(s1_c_reg - CB'(DC));
            assign top_ok_next[gl]  = (s1_r_reg >= RB'(DR + 1));
            assign left_ok_next[gl] = (s1_c_reg >= CB'(DC + 1));

            for (gt = 0; gt < NUM_TAPS; gt++)
            begin : g_tap
                localparam int WR = gt / 9;
                localparam int WC = (gt / 3) % 3;
                localparam int CH = gt % 3;
                localparam int KR = CR + 1 - WR;
                localparam int KC = CC + 1 - WC;
                if (KR >= 0 && KR <= 2 && KC >= 0 && KC <= 2)
                begin : g_on
                    // zero the tap when its neighbor falls above or left of the image
                    assign lane_coef[gl][gt] =
                        ((WR != CR - 1) || s2_top_ok_reg[gl]) &&
                        ((WC != CC - 1) || s2_left_ok_reg[gl])
                        ? coef_all[CH*9 + KR*3 + KC] : '0;
                end
                else
                begin : g_off
                    assign lane_coef[gl][gt] = '0;
                end
            end

            cthz_lane #(
                .PIXEL_BITS (PIXEL_BITS),
                .COEF_BITS  (COEF_BITS)
            ) u_lane (
                .clk  (clk),
                .en   (adv),
                .pix  (win_reg),
                .coef (lane_coef[gl]),
                .sum  (lane_sum[gl])
            );
        end
    endgenerate

    // bookkeeping that follows the four lane stages
    logic       a_valid_reg;
    logic       b_valid_reg;
    logic       c_valid_reg;
    lane_meta_t a_meta_reg;
    lane_meta_t b_meta_reg;
    lane_meta_t c_meta_reg;
    lane_meta_t d_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= s2_valid_reg;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_meta_reg <= s2_meta_reg;
            b_meta_reg <= a_meta_reg;
            c_meta_reg <= b_meta_reg;
            d_meta_reg <= c_meta_reg;
        end
    end

    cthz_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d_valid_reg),
        .meta     (d_meta_reg),
        .value    (lane_sum),
        .can_take (can_take),
        .res_out  (res_out)
    );

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not enter stage 1");

    a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.frame_end |->
            (res_out.out_col == COORD_BITS'(w_eff - (CB+1)'(1))) &&
            (res_out.out_row == COORD_BITS'(h_eff - (RB+1)'(1))))
        else $error("frame end flagged away from the last pixel");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && !adv |=> d_valid_reg && $stable(d_meta_reg))
        else $error("merge input changed while stalled");
endmodule

[hw/rtl/cthz_line_mem.sv]
`timescale 1ns / 1ps
module cthz_line_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 96
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[hw/rtl/cthz_lane.sv]
`timescale 1ns / 1ps
module cthz_lane #(
    parameter int PIXEL_BITS = 16,
    parameter int COEF_BITS  = 12
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [PIXEL_BITS-1:0]         pix  [cthz_pkg::NUM_TAPS],
    input  logic signed [COEF_BITS-1:0]          coef [cthz_pkg::NUM_TAPS],
    output logic signed [cthz_pkg::VALUE_BITS-1:0] sum
);
    import cthz_pkg::*;

    localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 5;

    logic signed [PROD_BITS-1:0]  prod_reg [NUM_TAPS];
    logic signed [ACC_BITS-1:0]   part_reg [9];
    logic signed [ACC_BITS-1:0]   mid_reg  [3];
    logic signed [ACC_BITS-1:0]   total;
    logic signed [VALUE_BITS-1:0] sat;
    logic signed [VALUE_BITS-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                prod_reg[i] <= pix[i] * coef[i];
            end
            for (int j = 0; j < 9; j++)
            begin
                part_reg[j] <= ACC_BITS'(prod_reg[3*j]) + ACC_BITS'(prod_reg[3*j+1])
                             + ACC_BITS'(prod_reg[3*j+2]);
            end
            for (int j = 0; j < 3; j++)
            begin
                mid_reg[j] <= part_reg[3*j] + part_reg[3*j+1] + part_reg[3*j+2];
            end
            sum_reg <= sat;
        end
    end

    assign total = mid_reg[0] + mid_reg[1] + mid_reg[2];

    generate
        if (ACC_BITS > VALUE_BITS)
        begin : g_sat
            localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(32'sh7FFFFFFF);
            localparam logic signed [ACC_BITS-1:0] SAT_LO = ACC_BITS'(32'sh80000000);
            always_comb
            begin
                if (total > SAT_HI)
                begin
                    sat = 32'sh7FFFFFFF;
                end
                else if (total < SAT_LO)
                begin
                    sat = 32'sh80000000;
                end
                else
                begin
                    sat = VALUE_BITS'(total);
                end
            end
        end
        else
        begin : g_ext
            assign sat = VALUE_BITS'(total);
        end
    endgenerate

    assign sum = sum_reg;
endmodule

[hw/rtl/cthz_merge.sv]
`timescale 1ns / 1ps
module cthz_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  cthz_pkg::lane_meta_t                   meta,
    input  logic signed [cthz_pkg::VALUE_BITS-1:0] value [cthz_pkg::NUM_LANES],
    output logic                                   can_take,
    cthz_res_if.source                             res_out
);
    import cthz_pkg::*;

    logic [NUM_LANES-1:0]         pend_reg;
    logic [NUM_LANES-1:0]         pend_next;
    lane_meta_t                   pmeta_reg;
    logic signed [VALUE_BITS-1:0] pval_reg [NUM_LANES];
    logic                         out_valid_reg;
    logic signed [VALUE_BITS-1:0] out_value_reg;
    coord_t                       out_row_reg;
    coord_t                       out_col_reg;
    logic                         out_fe_reg;
    logic                         pop;
    logic                         load;
    logic [NUM_LANES-1:0]         sel;
    logic [NUM_LANES-1:0]         left;

    // lowest pending lane goes first, matching result order
    always_comb
    begin
        sel = '0;
        for (int l = NUM_LANES - 1; l >= 0; l--)
        begin
            if (pend_reg[l])
            begin
                sel = '0;
                sel[l] = 1'b1;
            end
        end
    end

    assign pop      = (|pend_reg) && (!out_valid_reg || res_out.ready);
    assign left     = pop ? (pend_reg & ~sel) : pend_reg;
    assign can_take = (left == '0);
    assign load     = in_valid && can_take;
    assign pend_next = load ? meta.en : left;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pmeta_reg <= meta;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                pval_reg[l] <= value[l];
            end
        end
        if (pop)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if (sel[l])
                begin
                    out_value_reg <= pval_reg[l];
                    out_row_reg   <= pmeta_reg.row[l];
                    out_col_reg   <= pmeta_reg.col[l];
                end
            end
            // only the bottom-right lane closes the frame
            out_fe_reg <= sel[NUM_LANES-1];
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.conv_value = out_value_reg;
    assign res_out.out_row    = out_row_reg;
    assign res_out.out_col    = out_col_reg;
    assign res_out.frame_end  = out_fe_reg;
endmodule

[test/conv3x3_three_channel_zero_pad_top_test.sv]
`timescale 1ns / 1ps
module conv3x3_three_channel_zero_pad_top_test;
    import cthz_pkg::*;

    localparam int LINE_MAX  = 1024;
    localparam int ROWS_MAX  = 1024;
    localparam int PIX_BITS  = 16;
    localparam int COEF_W    = 12;
    localparam int SETTLE_CYCLES = 16;

    typedef logic signed [PIX_BITS-1:0] pixel_t;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        coord_t                       row;
        coord_t                       col;
        logic                         frame_end;
    } conv_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    cthz_pix_if #(.PIXEL_BITS(PIX_BITS)) pix ();
    cthz_res_if res ();

    conv3x3_three_channel_zero_pad_top #(
        .MAX_ROW_LENGTH(LINE_MAX),
        .MAX_ROWS      (ROWS_MAX),
        .PIXEL_BITS    (PIX_BITS),
        .COEF_BITS     (COEF_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix),
        .res_out  (res),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // shadow of the block: registers, line rows, window and raster position
    logic [KERN_BITS-1:0] kern_shadow [NUM_KERN];
    logic [SIZE_BITS-1:0] rows_reg;
    logic [SIZE_BITS-1:0] length_reg;
    longint line_rows [2][LINE_MAX][NUM_CHAN];
    longint window [3][3][NUM_CHAN];
    int cur_row;
    int cur_col;

    conv_result_t conv_expected [$];

    int send_idle_pct;
    int recv_idle_pct;
    logic hold_off;
    int pixels_sent;
    int results_checked;
    int mismatches;

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("Timeout waiting for results");
        $display("Some tests failed");
        $finish;
    end

    function automatic int clamp_size(logic [SIZE_BITS-1:0] v, int maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic longint coef_at(int ch, int kr, int kc);
        int k;
        logic [KERN_BITS-1:0] w;
        logic signed [COEF_W-1:0] v;
        k = ch * 9 + kr * 3 + kc;
        w = kern_shadow[k / COEFS_PER_WORD];
        v = w[(k % COEFS_PER_WORD) * COEF_W +: COEF_W];
        return longint'(v);
    endfunction

    function automatic void push_conv(int cr, int cc, int r, int c, int h, int w, logic fe);
        longint acc;
        conv_result_t e;
        acc = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (cr + dr >= 0 && cr + dr <= 2 && r + dr >= 0 && r + dr < h &&
                    cc + dc >= 0 && cc + dc <= 2 && c + dc >= 0 && c + dc < w)
                    for (int ch = 0; ch < NUM_CHAN; ch++)
                        acc += window[cr + dr][cc + dc][ch] * coef_at(ch, 1 - dr, 1 - dc);
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        e.value = acc[31:0];
        e.row = r[COORD_BITS-1:0];
        e.col = c[COORD_BITS-1:0];
        e.frame_end = fe;
        conv_expected.push_back(e);
    endfunction

    function automatic void predict_pixel(pixel_t a, pixel_t b, pixel_t c);
        int h;
        int w;
        int r;
        int cl;
        longint p [NUM_CHAN];
        h = clamp_size(rows_reg, ROWS_MAX);
        w = clamp_size(length_reg, LINE_MAX);
        p[0] = a;
        p[1] = b;
        p[2] = c;
        if (cur_row >= h || cur_col >= w)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        cl = cur_col;
        for (int wr = 0; wr < 3; wr++)
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                window[wr][0][ch] = window[wr][1][ch];
                window[wr][1][ch] = window[wr][2][ch];
            end
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            window[0][2][ch] = line_rows[0][cl][ch];
            window[1][2][ch] = line_rows[1][cl][ch];
            window[2][2][ch] = p[ch];
            line_rows[0][cl][ch] = line_rows[1][cl][ch];
            line_rows[1][cl][ch] = p[ch];
        end
        if (r >= 1)
        begin
            if (cl >= 1)
                push_conv(1, 1, r - 1, cl - 1, h, w, 1'b0);
            if (cl == w - 1)
                push_conv(1, 2, r - 1, cl, h, w, 1'b0);
        end
        if (r == h - 1)
        begin
            if (cl >= 1)
                push_conv(2, 1, r, cl - 1, h, w, 1'b0);
            if (cl == w - 1)
                push_conv(2, 2, r, cl, h, w, 1'b1);
        end
        cur_col++;
        if (cur_col >= w)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h)
                cur_row = 0;
        end
    endfunction

    // receiver: check each transaction, then pick ready for the next cycle
    always @(posedge clk)
    begin
        conv_result_t e;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (conv_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result value=%0d row=%0d col=%0d end=%0b",
                                 res.conv_value, res.out_row, res.out_col, res.frame_end);
                end
                else
                begin
                    e = conv_expected.pop_front();
                    results_checked++;
                    if (res.conv_value !== e.value || res.out_row !== e.row ||
                        res.out_col !== e.col || res.frame_end !== e.frame_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch exp value=%0d row=%0d col=%0d end=%0b, got value=%0d row=%0d col=%0d end=%0b",
                                     e.value, e.row, e.col, e.frame_end, res.conv_value,
                                     res.out_row, res.out_col, res.frame_end);
                    end
                end
            end
            if (hold_off)
                res.ready <= 1'b0;
            else
                res.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ROW_COUNT)
            rows_reg = value[SIZE_BITS-1:0];
        else if (idx == REG_ROW_LENGTH)
            length_reg = value[SIZE_BITS-1:0];
        else
            kern_shadow[idx - REG_KERN_WORD0] = value[KERN_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic write_kernel(logic [KERN_BITS-1:0] words [NUM_KERN]);
        for (int i = 0; i < NUM_KERN; i++)
            write_reg(REG_KERN_WORD0 + CFG_INDEX_BITS'(i), words[i]);
    endtask

    task automatic write_random_kernel();
        logic [KERN_BITS-1:0] words [NUM_KERN];
        for (int i = 0; i < NUM_KERN; i++)
            words[i] = KERN_BITS'({$urandom, $urandom});
        write_kernel(words);
    endtask

    // every coefficient set to the same value
    task automatic write_flat_kernel(logic [COEF_W-1:0] cf);
        logic [KERN_BITS-1:0] words [NUM_KERN];
        for (int i = 0; i < NUM_KERN; i++)
            words[i] = {COEFS_PER_WORD{cf}};
        write_kernel(words);
    endtask

    task automatic write_size(int h, int w);
        write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(h));
        write_reg(REG_ROW_LENGTH, CFG_DATA_BITS'(w));
    endtask

    task automatic send_pixel(pixel_t a, pixel_t b, pixel_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.chan_a <= a;
        pix.chan_b <= b;
        pix.chan_c <= c;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        predict_pixel(a, b, c);
        pixels_sent++;
    endtask

    function automatic pixel_t rand_pixel();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return pixel_t'($urandom);
        endcase
    endfunction

    task automatic send_pixels(int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel(), rand_pixel(), rand_pixel());
    endtask

    // drop valid, drain expectations, then cover the pipeline latency
    task automatic settle();
        pix.valid <= 1'b0;
        while (conv_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_extreme_values();
        write_flat_kernel(12'h7FF);
        for (int i = 0; i < 4; i++)
            send_pixel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        settle();
        write_flat_kernel(12'h800);
        for (int i = 0; i < 4; i++)
            send_pixel(16'sh8000, 16'sh8000, 16'sh8000);
        settle();
    endtask

    task automatic test_size_clamping();
        write_random_kernel();
        write_size(0, 1);
        send_pixels(4);
        settle();
        write_size(3, 3);
        send_pixels(9);
        settle();
    endtask

    task automatic test_restart_on_shrink();
        write_size(4, 5);
        send_pixels(12);
        settle();
        // position now row 2: two rows force a fresh image
        write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(2));
        send_pixels(10);
        settle();
    endtask

    task automatic test_widest_row();
        write_random_kernel();
        // oversize length clamps to the line memory; shrink it to start over
        write_size(2, 2047);
        send_pixels(20);
        settle();
        write_reg(REG_ROW_LENGTH, CFG_DATA_BITS'(8));
        send_pixels(16);
        settle();
    endtask

    task automatic test_tallest_image();
        write_random_kernel();
        write_size(2047, 2);
        send_pixels(20);
        settle();
        write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(2));
        send_pixels(4);
        settle();
    endtask

    task automatic test_random_images(int target);
        int start;
        int h;
        int w;
        start = pixels_sent;
        while (pixels_sent - start < target)
        begin
            write_random_kernel();
            h = $urandom_range(2, 6);
            w = $urandom_range(2, 8);
            write_size(h, w);
            if ($urandom_range(5) == 0)
            begin
                // broken image: stop partway, then shrink the rows to restart
                send_pixels(2 * w + $urandom_range(w - 1));
                settle();
                write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(2));
                h = 2;
            end
            send_pixels(h * w);
            settle();
        end
    endtask

    task automatic test_output_hold_off();
        write_random_kernel();
        write_size(6, 8);
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
            send_pixels(48);
        join
        settle();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.chan_a = '0;
        pix.chan_b = '0;
        pix.chan_c = '0;
        res.ready = 1'b0;
        hold_off = 1'b0;
        for (int i = 0; i < NUM_KERN; i++)
            kern_shadow[i] = '0;
        rows_reg = 2;
        length_reg = 2;
        cur_row = 0;
        cur_col = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                for (int ch = 0; ch < NUM_CHAN; ch++)
                    window[r][c][ch] = 0;
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < LINE_MAX; c++)
                for (int ch = 0; ch < NUM_CHAN; ch++)
                    line_rows[r][c][ch] = 0;
        pixels_sent = 0;
        results_checked = 0;
        mismatches = 0;
        send_idle_pct = 31;
        recv_idle_pct = 67;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset kernel is all zero at the default 2x2 size
        send_pixels(4);
        settle();
        test_extreme_values();
        test_size_clamping();
        test_restart_on_shrink();
        test_random_images(25);
        send_idle_pct = 67;
        recv_idle_pct = 31;
        test_random_images(25);
        test_widest_row();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_images(25);
        test_tallest_image();
        test_output_hold_off();
        settle();

        $display("Sent %0d pixels and checked %0d convolution results", pixels_sent,
                 results_checked);
        $display("Covered extreme values, size clamping, restarts and oversize images");
        if (mismatches == 0 && conv_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
